// ===== sv/ppd_pkg.sv =====
// ppd_pkg: shared types and constants for the palette pixel doubler.
// Item structs, command codes, field widths and default geometry.
// No dependencies.
package ppd_pkg;

    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 19;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int PAL_DEPTH = 1 << IDX_W;

    localparam int SRC_WIDTH_DEF  = 320;
    localparam int SRC_HEIGHT_DEF = 200;
    localparam int DST_WIDTH_DEF  = 640;
    localparam int DST_HEIGHT_DEF = 480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   index_value;
        logic [COLOR_W-1:0] entry_color;
        logic               frame_start;
    } src_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  word_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_of_pixel;
    } dst_item_t;

    // pixel waiting between lookup and write-out
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic              upscale;
    } pix_t;

endpackage

// ===== sv/palette_pixel_doubler.sv =====
// palette_pixel_doubler: palette lookup with 2x2 or centered 1:1 framebuffer writes.
// Depends on ppd_pkg, ppd_palette and ppd_emit.
//
//   port     | dir | payload     | meaning
//   src_*    | in  | src_item_t  | pixel index or palette entry write
//   dst_*    | out | dst_item_t  | framebuffer word address and color
//   cfg_*    | in  | 1 bit       | upscale_on
//
// A pixel item is registered in the palette read stage, then leaves as 4 items
// (upscale) or 1 item (centered), one per cycle from the output register while
// dst_ready is high. Palette writes emit nothing. Reset sets upscale on and
// position 0; palette contents are undefined until written. A stalled output
// holds one pixel in the lookup stage and then stops src_ready.
module palette_pixel_doubler
    import ppd_pkg::*;
#(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int DST_WIDTH  = DST_WIDTH_DEF,
    parameter int DST_HEIGHT = DST_HEIGHT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_item,
    output logic      dst_valid,
    input  logic      dst_ready,
    output dst_item_t dst_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    localparam int COL_OFF = (DST_WIDTH > SRC_WIDTH) ? (DST_WIDTH - SRC_WIDTH) / 2 : 0;
    localparam int ROW_OFF = (DST_HEIGHT > SRC_HEIGHT) ? (DST_HEIGHT - SRC_HEIGHT) / 2 : 0;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SRC_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SRC_HEIGHT - 1);

    logic               upscale_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               s1_valid_reg, s1_valid_next;
    pix_t               s1_reg, s1_next;
    logic               s1_take;
    logic               accept, pix_accept, wr_accept;
    logic [COL_W-1:0]   col_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [ADDR_W-1:0]  r_full, c_full;
    logic [COLOR_W-1:0] pal_color;

    assign cfg_ready  = 1'b1;
    assign src_ready  = !s1_valid_reg || s1_take;
    assign accept     = src_valid && src_ready;
    assign pix_accept = accept && (src_item.cmd == CMD_PIXEL);
    assign wr_accept  = accept && (src_item.cmd == CMD_WRITE);

    assign col_eff = src_item.frame_start ? '0 : col_reg;
    assign row_eff = src_item.frame_start ? '0 : row_reg;

    always_comb
    begin
        if (upscale_reg)
        begin
            r_full = ADDR_W'({row_eff, 1'b0});
            c_full = ADDR_W'({col_eff, 1'b0});
        end
        else
        begin
            r_full = ADDR_W'(row_eff) + ADDR_W'(ROW_OFF);
            c_full = ADDR_W'(col_eff) + ADDR_W'(COL_OFF);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (col_eff == COL_LAST)
            begin
                col_next = '0;
                row_next = (row_eff == ROW_LAST) ? '0 : row_eff + ROW_W'(1);
            end
            else
            begin
                col_next = col_eff + COL_W'(1);
                row_next = row_eff;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        if (pix_accept)
        begin
            s1_valid_next   = 1'b1;
            s1_next.base    = ADDR_W'(r_full * ADDR_W'(DST_WIDTH) + c_full);
            s1_next.upscale = upscale_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upscale_reg  <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                upscale_reg <= cfg_data;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    ppd_palette u_palette
    (
        .clk     (clk),
        .wr_en   (wr_accept),
        .wr_addr (src_item.index_value),
        .wr_data (src_item.entry_color),
        .rd_en   (pix_accept),
        .rd_addr (src_item.index_value),
        .rd_data (pal_color)
    );

    ppd_emit
    #(
        .DST_WIDTH (DST_WIDTH)
    )
    u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (s1_valid_reg),
        .pix       (s1_reg),
        .pix_color (pal_color),
        .pix_take  (s1_take),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item)
    );

endmodule

// ===== sv/ppd_palette.sv =====
// ppd_palette: 256 x 24 palette memory, one write and one registered read port.
// Depends on ppd_pkg for widths.
module ppd_palette
    import ppd_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ppd_emit.sv =====
// ppd_emit: output register and write sequencer, one or four items per pixel.
// Depends on ppd_pkg for item types.
module ppd_emit
    import ppd_pkg::*;
#(
    parameter int DST_WIDTH = DST_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  pix_t               pix,
    input  logic [COLOR_W-1:0] pix_color,
    output logic               pix_take,
    output logic               dst_valid,
    input  logic               dst_ready,
    output dst_item_t          dst_item
);

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(DST_WIDTH);

    logic               out_valid_reg, out_valid_next;
    dst_item_t          out_reg, out_next;
    logic               more_reg, more_next;
    logic [1:0]         phase_reg, phase_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               advance;

    assign advance = !out_valid_reg || dst_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        more_next      = more_reg;
        phase_next     = phase_reg;
        base_next      = base_reg;
        color_next     = color_reg;
        pix_take       = 1'b0;
        if (advance)
        begin
            if (more_reg)
            begin
                phase_next     = phase_reg + 2'd1;
                out_valid_next = 1'b1;
                out_next.word_address = base_reg
                    + (phase_next[0] ? ROW_STEP : '0)
                    + ADDR_W'(phase_next[1]);
                out_next.pixel_color   = color_reg;
                out_next.last_of_pixel = (phase_next == 2'd3);
                more_next              = (phase_next != 2'd3);
            end
            else if (pix_valid)
            begin
                pix_take       = 1'b1;
                phase_next     = 2'd0;
                base_next      = pix.base;
                color_next     = pix_color;
                out_valid_next = 1'b1;
                out_next.word_address  = pix.base;
                out_next.pixel_color   = pix_color;
                out_next.last_of_pixel = !pix.upscale;
                more_next              = pix.upscale;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            more_reg      <= 1'b0;
            phase_reg     <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            more_reg      <= more_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        base_reg  <= base_next;
        color_reg <= color_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for palette_pixel_doubler, a directed table, random phases
// and a sweep past the end of a row, every framebuffer write checked against a predictor.
// Depends on ppd_pkg and palette_pixel_doubler.
module tb_top;
    import ppd_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int SRC_W      = SRC_WIDTH_DEF;
    localparam int SRC_H      = SRC_HEIGHT_DEF;
    localparam int DST_W      = DST_WIDTH_DEF;
    localparam int DST_H      = DST_HEIGHT_DEF;
    localparam int COL_OFF    = (DST_W > SRC_W) ? (DST_W - SRC_W) / 2 : 0;
    localparam int ROW_OFF    = (DST_H > SRC_H) ? (DST_H - SRC_H) / 2 : 0;
    localparam int SETTLE_CYC = 16;
    localparam int HOLD_CYC   = 120;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 8;
    localparam int SWEEP_LEN  = SRC_W + 8;
    localparam longint LIMIT_TIME = 64'd18_000_000;

    typedef struct {
        bit        is_cfg;
        bit        cfg_val;
        src_item_t item;
        bit        typed;
        dst_item_t first;
    } row_t;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_ready;
    src_item_t src_item;
    logic      dst_valid;
    logic      dst_ready;
    dst_item_t dst_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // predictor state
    logic [COLOR_W-1:0] pal_mirror [PAL_DEPTH];
    bit   [PAL_DEPTH-1:0] pal_loaded;
    logic [IDX_W-1:0]   loaded_list [$];
    logic [COL_W-1:0]   pos_col;
    logic [ROW_W-1:0]   pos_row;
    bit                 double_mode;

    dst_item_t fb_writes_q [$];
    int        n_fail   = 0;
    int        gap_pct  = 0;
    bit        hold_req = 1'b0;

    palette_pixel_doubler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] fb_addr(int unsigned r, int unsigned c);
        return ADDR_W'(r * DST_W + c);
    endfunction

    function automatic void push_write(int unsigned r, int unsigned c,
                                       logic [COLOR_W-1:0] color, logic last);
        dst_item_t w;
        w.word_address  = fb_addr(r, c);
        w.pixel_color   = color;
        w.last_of_pixel = last;
        fb_writes_q.push_back(w);
    endfunction

    function automatic void place_pixel(src_item_t it);
        int unsigned        r;
        int unsigned        c;
        logic [COLOR_W-1:0] color;
        if (it.cmd == CMD_WRITE)
        begin
            pal_mirror[it.index_value] = it.entry_color;
            if (!pal_loaded[it.index_value])
            begin
                pal_loaded[it.index_value] = 1'b1;
                loaded_list.push_back(it.index_value);
            end
            return;
        end
        if (it.frame_start)
        begin
            pos_col = '0;
            pos_row = '0;
        end
        c = pos_col;
        r = pos_row;
        color = pal_mirror[it.index_value];
        if (double_mode)
        begin
            push_write(2 * r,     2 * c,     color, 1'b0);
            push_write(2 * r + 1, 2 * c,     color, 1'b0);
            push_write(2 * r,     2 * c + 1, color, 1'b0);
            push_write(2 * r + 1, 2 * c + 1, color, 1'b1);
        end
        else
            push_write(r + ROW_OFF, c + COL_OFF, color, 1'b1);
        c++;
        if (c >= SRC_W)
        begin
            c = 0;
            r++;
            if (r >= SRC_H)
                r = 0;
        end
        pos_col = COL_W'(c);
        pos_row = ROW_W'(r);
    endfunction

    function automatic row_t r_wr(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color, logic fs);
        row_t r;
        r = '{default: 0};
        r.item.cmd         = CMD_WRITE;
        r.item.index_value = idx;
        r.item.entry_color = color;
        r.item.frame_start = fs;
        return r;
    endfunction

    function automatic row_t r_px(logic [IDX_W-1:0] idx, logic fs);
        row_t r;
        r = '{default: 0};
        r.item.cmd         = CMD_PIXEL;
        r.item.index_value = idx;
        r.item.entry_color = COLOR_W'(32'h00C0FFEE);
        r.item.frame_start = fs;
        return r;
    endfunction

    function automatic row_t r_chk(logic [IDX_W-1:0] idx, logic fs, logic [ADDR_W-1:0] a,
                                   logic [COLOR_W-1:0] color, logic last);
        row_t r;
        r = r_px(idx, fs);
        r.typed               = 1'b1;
        r.first.word_address  = a;
        r.first.pixel_color   = color;
        r.first.last_of_pixel = last;
        return r;
    endfunction

    function automatic row_t r_cfg(bit v);
        row_t r;
        r = '{default: 0};
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic src_item_t rand_item();
        src_item_t it;
        it.entry_color = COLOR_W'($urandom());
        it.frame_start = ($urandom_range(0, 59) == 0);
        if (loaded_list.size() == 0 || $urandom_range(0, 4) == 0)
        begin
            it.cmd         = CMD_WRITE;
            it.index_value = IDX_W'($urandom());
            it.frame_start = 1'($urandom_range(0, 1));
        end
        else
        begin
            it.cmd         = CMD_PIXEL;
            it.index_value = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        end
        return it;
    endfunction

    task automatic drive_src(src_item_t it, bit typed, dst_item_t first);
        int slot;
        src_valid <= 1'b1;
        src_item  <= it;
        do @(posedge clk); while (!src_ready);
        slot = fb_writes_q.size();
        place_pixel(it);
        if (typed)
            fb_writes_q[slot] = first;
    endtask

    task automatic maybe_gap();
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // wait for every expected write, then let a pending palette write finish
    task automatic settle();
        src_valid <= 1'b0;
        while (fb_writes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_mode(bit v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        double_mode = v;
    endtask

    initial
    begin
        dst_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dst_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                dst_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
                dst_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_writes
        dst_item_t want;
        if (rst_n && dst_valid && dst_ready)
        begin
            if (fb_writes_q.size() == 0)
            begin
                $error("unexpected item: word_address %0d pixel_color %06h",
                       dst_item.word_address, dst_item.pixel_color);
                n_fail++;
            end
            else
            begin
                want = fb_writes_q.pop_front();
                if (dst_item.word_address !== want.word_address)
                begin
                    $error("word_address: expected %0d, actual %0d",
                           want.word_address, dst_item.word_address);
                    n_fail++;
                end
                if (dst_item.pixel_color !== want.pixel_color)
                begin
                    $error("pixel_color: expected %06h, actual %06h",
                           want.pixel_color, dst_item.pixel_color);
                    n_fail++;
                end
                if (dst_item.last_of_pixel !== want.last_of_pixel)
                begin
                    $error("last_of_pixel: expected %0b, actual %0b",
                           want.last_of_pixel, dst_item.last_of_pixel);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin : stim
        row_t      plan [$];
        src_item_t it;
        bit        mode;
        int        ph;
        int        k;

        rst_n       <= 1'b0;
        src_valid   <= 1'b0;
        src_item    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 1'b0;
        pal_loaded  = '0;
        pos_col     = '0;
        pos_row     = '0;
        double_mode = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // upscale is on out of reset; frame_start on a palette write must not move position
        plan = '{
            r_wr(8'h00, 24'h000000, 1'b0),
            r_wr(8'hFF, 24'hFFFFFF, 1'b0),
            r_wr(8'h5A, 24'hA5C33C, 1'b1),
            r_chk(8'h00, 1'b0, 19'd0, 24'h000000, 1'b0),
            r_chk(8'hFF, 1'b0, 19'd2, 24'hFFFFFF, 1'b0),
            r_px(8'h5A, 1'b0),
            r_wr(8'h80, 24'h123456, 1'b1),
            r_chk(8'h80, 1'b0, 19'd6, 24'h123456, 1'b0),
            r_chk(8'hFF, 1'b1, 19'd0, 24'hFFFFFF, 1'b0),
            r_wr(8'hFF, 24'h000001, 1'b0),
            r_chk(8'hFF, 1'b0, 19'd2, 24'h000001, 1'b0),
            r_cfg(1'b0),
            r_chk(8'h00, 1'b1, 19'(ROW_OFF * DST_W + COL_OFF), 24'h000000, 1'b1),
            r_chk(8'hFF, 1'b0, 19'(ROW_OFF * DST_W + COL_OFF + 1), 24'h000001, 1'b1),
            r_px(8'h5A, 1'b0),
            r_wr(8'h01, 24'h800000, 1'b0),
            r_px(8'h01, 1'b0),
            r_cfg(1'b1),
            r_px(8'h01, 1'b0),
            r_chk(8'h80, 1'b1, 19'd0, 24'h123456, 1'b0)
        };

        gap_pct = 20;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                set_mode(plan[i].cfg_val);
            else
            begin
                drive_src(plan[i].item, plan[i].typed, plan[i].first);
                maybe_gap();
            end
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            mode = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            set_mode(mode);
            gap_pct = (ph == 3 || ph == 5) ? 0 : 15;
            // long output stall while items keep coming
            if (ph == 3)
                hold_req = 1'b1;
            for (k = 0; k < PHASE_LEN; k++)
            begin
                drive_src(rand_item(), 1'b0, '0);
                maybe_gap();
            end
        end

        // sweep in upscale mode past the end of the first row, no idling
        set_mode(1'b1);
        gap_pct = 0;
        for (k = 0; k < SWEEP_LEN; k++)
        begin
            it.cmd         = CMD_PIXEL;
            it.index_value = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            it.entry_color = COLOR_W'($urandom());
            it.frame_start = (k == 0);
            drive_src(it, 1'b0, '0);
        end

        settle();
        if (n_fail == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
